// ===== hdl/hce_pkg.sv =====
// Package for the Huffman code build, encode and decode unit.
// Holds field widths, operation and status codes, and the types shared by
// the controller and the datapath. Depends on nothing.
package hce_pkg;

   localparam int OP_W     = 3;
   localparam int SYM_W    = 8;
   localparam int FREQ_W   = 16;
   localparam int STATUS_W = 2;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;

   typedef enum logic [OP_W-1:0] {
      OP_COUNT  = 3'd0,
      OP_SET    = 3'd1,
      OP_BUILD  = 3'd2,
      OP_ENCODE = 3'd3,
      OP_DECODE = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_ABSENT   = 2'd1,
      ST_TOO_LONG = 2'd2,
      ST_NO_TREE  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_CNT_WR,
      DP_SET_WR,
      DP_CLEAR,
      DP_BUILD_INIT,
      DP_LEAF_RD,
      DP_LEAF_WR,
      DP_BUILD_EMPTY,
      DP_BUILD_DONE,
      DP_SCAN_INIT,
      DP_SCAN_RD,
      DP_SCAN_CMP,
      DP_TAKE_A,
      DP_TAKE_B,
      DP_LINK_B,
      DP_ENC_CHK,
      DP_ENC_LEAF,
      DP_ENC_PRD,
      DP_ENC_RRD,
      DP_ENC_STEP,
      DP_ENC_FIN,
      DP_DEC_CHK,
      DP_DEC_STEP,
      DP_DEC_SYM,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic tree_ready;
      logic leaf_more;
      logic no_leaves;
      logic merge_more;
      logic scan_more;
      logic second;
      logic enc_fail;
      logic enc_absent;
      logic enc_done;
      logic dec_noready;
      logic dec_rootleaf;
      logic next_bad;
      logic next_leaf;
   } stat_type;

endpackage

// ===== hdl/hce_req_if.sv =====
// Request channel interface of the Huffman unit: valid, ready and one item.
// Depends on hce_pkg.
interface hce_req_if
   import hce_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SYM_W-1:0]    symbol;
   logic [FREQ_W-1:0]   frequency;
   logic                code_bit;

   modport source (output valid, operation, symbol, frequency, code_bit, input ready);
   modport sink (input valid, operation, symbol, frequency, code_bit, output ready);
endinterface

// ===== hdl/hce_rsp_if.sv =====
// Response channel interface of the Huffman unit: valid, ready and one item.
// Depends on hce_pkg.
interface hce_rsp_if
   import hce_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [SYM_W-1:0]     decoded_symbol;
   logic [CODE_W-1:0]    code_bits;
   logic [LEN_W-1:0]     code_length;

   modport source (output valid, status, decoded_symbol, code_bits, code_length,
                   input ready);
   modport sink (input valid, status, decoded_symbol, code_bits, code_length,
                 output ready);
endinterface

// ===== hdl/huffman_code_build_encode_decode_unit.sv =====
// Top level of the Huffman code build, encode and decode unit.
// Depends on hce_pkg, hce_req_if, hce_rsp_if, hce_ctrl and hce_dp.
//
// Items enter on req_ch and results leave on rsp_ch, both valid/ready.
// An item is taken only when the unit is idle; one item is worked at a time.
// Count, set and clear return no result.
// Encode returns one result, with one parent link and one child compare
// per bit of the code through the tree memories.
// Decode returns a result only at a leaf or on an error.
// Build returns one result after a leaf pass over all symbols and the
// merging of the leaves: each merge scans all nodes twice through the one
// read port of the weight memory.
// The result register frees the unit at once: the next item is accepted
// while a result waits, and a second result waits only if the first is
// still unread. Reset clears the frequency table and drops the tree, so
// encode and decode answer no tree until the next build.
module huffman_code_build_encode_decode_unit
   import hce_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32,
   parameter int FREQ_BITS    = 16
) (
   input logic       clock,
   input logic       reset,
   hce_req_if.sink   req_ch,
   hce_rsp_if.source rsp_ch
);
   cmd_type  dp_cmd;
   stat_type dp_stat;

   hce_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_operation(req_ch.operation),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .stat(dp_stat), .cmd(dp_cmd));

   hce_dp #(
      .SYMBOL_COUNT(SYMBOL_COUNT), .MAX_CODE_LEN(MAX_CODE_LEN), .FREQ_BITS(FREQ_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(dp_cmd),
      .req_symbol(req_ch.symbol), .req_frequency(req_ch.frequency),
      .req_code_bit(req_ch.code_bit), .stat(dp_stat),
      .rsp_status(rsp_ch.status), .rsp_decoded_symbol(rsp_ch.decoded_symbol),
      .rsp_code_bits(rsp_ch.code_bits), .rsp_code_length(rsp_ch.code_length));

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_OK |->
         rsp_ch.code_bits == '0 && rsp_ch.code_length == '0)
      else $error("An error result carries code bits.");

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.code_length <= LEN_W'(CODE_W))
      else $error("A code length exceeds the code word.");

   a_reset_tree: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !dp_stat.tree_ready)
      else $error("A tree is marked ready right after reset.");
endmodule

// ===== hdl/hce_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module hce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/hce_dp.sv =====
// Datapath of the Huffman unit: frequency table, tree memories, scan, encode
// walk and decode cursor, driven one micro-operation per cycle.
// Depends on hce_pkg and hce_ram.
module hce_dp
   import hce_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32,
   parameter int FREQ_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic [FREQ_W-1:0]   req_frequency,
   input  logic                req_code_bit,
   output stat_type            stat,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SYM_W-1:0]    rsp_decoded_symbol,
   output logic [CODE_W-1:0]   rsp_code_bits,
   output logic [LEN_W-1:0]    rsp_code_length
);
   localparam int SW         = $clog2(SYMBOL_COUNT);
   localparam int NODE_MAX   = 2 * SYMBOL_COUNT - 1;
   localparam int NW         = $clog2(NODE_MAX);
   localparam int IW         = NW + 1;
   localparam int WB         = FREQ_BITS + SW;
   localparam int CODE_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam logic [32:0] FMAX_W = (33'd1 << FREQ_BITS) - 33'd1;
   localparam logic [FREQ_BITS-1:0] FMAX = FMAX_W[FREQ_BITS-1:0];

   logic [SYM_W-1:0]        sym_ff, sym_in;
   logic [FREQ_W-1:0]       fval_ff, fval_in;
   logic                    bit_ff, bit_in;
   logic [SYMBOL_COUNT-1:0] fvalid_ff, fvalid_in;
   logic [SW:0]             s_ff, s_in;
   logic [SW:0]             n_ff, n_in;
   logic [SW:0]             livecnt_ff, livecnt_in;
   logic [NW-1:0]           total_ff, total_in;
   logic [NW-1:0]           i_ff, i_in;
   logic                    found_ff, found_in;
   logic                    second_ff, second_in;
   logic [NW-1:0]           best_ff, best_in;
   logic [WB-1:0]           bw_ff, bw_in;
   logic [NW-1:0]           a_ff, a_in;
   logic [WB-1:0]           wa_ff, wa_in;
   logic [NW-1:0]           b_ff, b_in;
   logic [NW-1:0]           root_ff, root_in;
   logic [NW-1:0]           cursor_ff, cursor_in;
   logic                    ready_ff, ready_in;
   logic [NW-1:0]           node_ff, node_in;
   logic [NW-1:0]           up_ff, up_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic [STATUS_W-1:0]     pst_ff, pst_in;
   logic [SYM_W-1:0]        psym_ff, psym_in;
   logic [CODE_W-1:0]       pcode_ff, pcode_in;
   logic [LEN_W-1:0]        plen_ff, plen_in;
   logic [STATUS_W-1:0]     ost_ff, ost_in;
   logic [SYM_W-1:0]        osym_ff, osym_in;
   logic [CODE_W-1:0]       ocode_ff, ocode_in;
   logic [LEN_W-1:0]        olen_ff, olen_in;

   logic                 freq_we, weight_we, parent_we, left_we, right_we;
   logic                 nsym_we, leafof_we;
   logic [SW-1:0]        freq_wa, freq_ra;
   logic [FREQ_BITS-1:0] freq_wd, freq_rd;
   logic [NW-1:0]        weight_wa;
   logic [WB:0]          weight_wd, weight_rd;
   logic [NW-1:0]        parent_wa, parent_wd, parent_rd;
   logic [NW-1:0]        left_rd, right_ra, right_rd, dec_cur, next_node;
   logic [SW-1:0]        nsym_ra;
   logic [SYM_W-1:0]     nsym_rd;
   logic [NW:0]          leafof_rd;
   logic [SW-1:0]        sym_idx, s_idx;
   logic                 sym_ok;
   logic [FREQ_BITS-1:0] cnt_cur, leaf_cur, set_val;
   logic [32:0]          fval_w;

   assign sym_idx  = sym_ff[SW-1:0];
   assign s_idx    = s_ff[SW-1:0];
   assign sym_ok   = ({1'b0, sym_ff} < 9'(SYMBOL_COUNT));
   assign fval_w   = 33'(fval_ff);
   assign set_val  = (fval_w > FMAX_W) ? FMAX : fval_w[FREQ_BITS-1:0];
   assign cnt_cur  = fvalid_ff[sym_idx] ? freq_rd : '0;
   assign leaf_cur = fvalid_ff[s_idx] ? freq_rd : '0;
   assign freq_ra  = (cmd.op == DP_LEAF_RD) ? s_idx : sym_idx;

   assign dec_cur = (IW'(cursor_ff) >= IW'(NODE_MAX) || IW'(cursor_ff) < IW'(n_ff)) ?
                    root_ff : cursor_ff;
   assign next_node = bit_ff ? right_rd : left_rd;
   assign right_ra  = (cmd.op == DP_ENC_RRD) ? parent_rd : dec_cur;
   assign nsym_ra   = (cmd.op == DP_DEC_STEP) ? next_node[SW-1:0] : root_ff[SW-1:0];

   always_comb begin
      stat.tree_ready   = ready_ff;
      stat.leaf_more    = (s_ff < (SW+1)'(SYMBOL_COUNT));
      stat.no_leaves    = (n_ff == '0);
      stat.merge_more   = (livecnt_ff > (SW+1)'(1));
      stat.scan_more    = (i_ff < total_ff);
      stat.second       = second_ff;
      stat.enc_fail     = !ready_ff || !sym_ok;
      stat.enc_absent   = !leafof_rd[NW];
      stat.enc_done     = (node_ff == root_ff) || (len_ff > LEN_W'(CODE_LIMIT));
      stat.dec_noready  = !ready_ff;
      stat.dec_rootleaf = (IW'(root_ff) < IW'(n_ff));
      stat.next_bad     = (IW'(next_node) >= IW'(NODE_MAX));
      stat.next_leaf    = (IW'(next_node) < IW'(n_ff));
   end

   always_comb begin
      sym_in = sym_ff;       fval_in = fval_ff;       bit_in = bit_ff;
      fvalid_in = fvalid_ff;
      s_in = s_ff;           n_in = n_ff;             livecnt_in = livecnt_ff;
      total_in = total_ff;   i_in = i_ff;             found_in = found_ff;
      second_in = second_ff; best_in = best_ff;       bw_in = bw_ff;
      a_in = a_ff;           wa_in = wa_ff;           b_in = b_ff;
      root_in = root_ff;     cursor_in = cursor_ff;   ready_in = ready_ff;
      node_in = node_ff;     up_in = up_ff;           len_in = len_ff;
      code_in = code_ff;
      pst_in = pst_ff;       psym_in = psym_ff;       pcode_in = pcode_ff;
      plen_in = plen_ff;
      ost_in = ost_ff;       osym_in = osym_ff;       ocode_in = ocode_ff;
      olen_in = olen_ff;
      freq_we = 1'b0;   freq_wa = sym_idx;   freq_wd = set_val;
      weight_we = 1'b0; weight_wa = total_ff; weight_wd = {1'b1, wa_ff + bw_ff};
      parent_we = 1'b0; parent_wa = a_ff;    parent_wd = total_ff;
      left_we = 1'b0;   right_we = 1'b0;
      nsym_we = 1'b0;   leafof_we = 1'b0;
      case (cmd.op)
         DP_LOAD: begin
            sym_in  = req_symbol;
            fval_in = req_frequency;
            bit_in  = req_code_bit;
         end
         DP_CNT_WR: begin
            if (sym_ok && cnt_cur != FMAX) begin
               freq_we = 1'b1;
               freq_wd = cnt_cur + FREQ_BITS'(1);
               fvalid_in[sym_idx] = 1'b1;
            end
         end
         DP_SET_WR: begin
            if (sym_ok) begin
               freq_we = 1'b1;
               fvalid_in[sym_idx] = 1'b1;
            end
         end
         DP_CLEAR: begin
            fvalid_in = '0;
            ready_in  = 1'b0;
            cursor_in = '0;
         end
         DP_BUILD_INIT: begin
            s_in = '0;  n_in = '0;  livecnt_in = '0;  total_in = '0;
            second_in = 1'b0;  ready_in = 1'b0;
         end
         DP_LEAF_WR: begin
            leafof_we = 1'b1;
            if (leaf_cur != '0) begin
               weight_we = 1'b1;
               weight_wa = NW'(n_ff);
               weight_wd = {1'b1, WB'(leaf_cur)};
               nsym_we   = 1'b1;
               n_in       = n_ff + (SW+1)'(1);
               livecnt_in = livecnt_ff + (SW+1)'(1);
               total_in   = total_ff + NW'(1);
            end
            s_in = s_ff + (SW+1)'(1);
         end
         DP_BUILD_EMPTY: begin
            ready_in  = 1'b0;
            cursor_in = '0;
            pst_in = ST_NO_TREE;  psym_in = '0;  pcode_in = '0;  plen_in = '0;
         end
         DP_BUILD_DONE: begin
            root_in   = total_ff - NW'(1);
            cursor_in = total_ff - NW'(1);
            ready_in  = 1'b1;
            pst_in = ST_OK;  psym_in = '0;  pcode_in = '0;  plen_in = '0;
         end
         DP_SCAN_INIT: begin
            i_in     = '0;
            found_in = 1'b0;
         end
         DP_SCAN_CMP: begin
            if (weight_rd[WB] && (!found_ff || weight_rd[WB-1:0] < bw_ff)) begin
               best_in  = i_ff;
               bw_in    = weight_rd[WB-1:0];
               found_in = 1'b1;
            end
            i_in = i_ff + NW'(1);
         end
         DP_TAKE_A: begin
            weight_we = 1'b1;
            weight_wa = best_ff;
            weight_wd = {1'b0, bw_ff};
            a_in      = best_ff;
            wa_in     = bw_ff;
            second_in = 1'b1;
         end
         DP_TAKE_B: begin
            b_in      = best_ff;
            second_in = 1'b0;
            weight_we = 1'b1;
            left_we   = 1'b1;
            right_we  = 1'b1;
            parent_we = 1'b1;
         end
         DP_LINK_B: begin
            parent_we = 1'b1;
            parent_wa = b_ff;
            weight_we = 1'b1;
            weight_wa = b_ff;
            weight_wd = {1'b0, bw_ff};
            total_in   = total_ff + NW'(1);
            livecnt_in = livecnt_ff - (SW+1)'(1);
         end
         DP_ENC_CHK: begin
            pst_in = ready_ff ? ST_ABSENT : ST_NO_TREE;
            psym_in = '0;  pcode_in = '0;  plen_in = '0;
         end
         DP_ENC_LEAF: begin
            node_in = leafof_rd[NW-1:0];
            len_in  = '0;
            code_in = '0;
         end
         DP_ENC_RRD: begin
            up_in = parent_rd;
         end
         DP_ENC_STEP: begin
            if (right_rd == node_ff && !len_ff[LEN_W-1]) begin
               code_in[len_ff[LEN_W-2:0]] = 1'b1;
            end
            len_in  = len_ff + LEN_W'(1);
            node_in = up_ff;
         end
         DP_ENC_FIN: begin
            psym_in = '0;
            if (len_ff > LEN_W'(CODE_LIMIT)) begin
               pst_in = ST_TOO_LONG;  pcode_in = '0;  plen_in = '0;
            end else begin
               pst_in = ST_OK;  pcode_in = code_ff;  plen_in = len_ff;
            end
         end
         DP_DEC_CHK: begin
            pst_in = ST_NO_TREE;  psym_in = '0;  pcode_in = '0;  plen_in = '0;
            if (ready_ff) begin
               cursor_in = (IW'(root_ff) < IW'(n_ff)) ? root_ff : dec_cur;
            end
         end
         DP_DEC_STEP: begin
            pst_in = ST_NO_TREE;  psym_in = '0;  pcode_in = '0;  plen_in = '0;
            if (IW'(next_node) >= IW'(NODE_MAX) || IW'(next_node) < IW'(n_ff)) begin
               cursor_in = root_ff;
            end else begin
               cursor_in = next_node;
            end
         end
         DP_DEC_SYM: begin
            pst_in = ST_OK;  psym_in = nsym_rd;  pcode_in = '0;  plen_in = '0;
         end
         DP_EMIT: begin
            ost_in = pst_ff;  osym_in = psym_ff;  ocode_in = pcode_ff;  olen_in = plen_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff  <= '0;
         n_ff       <= '0;
         root_ff    <= '0;
         cursor_ff  <= '0;
         ready_ff   <= 1'b0;
         second_ff  <= 1'b0;
      end else begin
         fvalid_ff  <= fvalid_in;
         n_ff       <= n_in;
         root_ff    <= root_in;
         cursor_ff  <= cursor_in;
         ready_ff   <= ready_in;
         second_ff  <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;      fval_ff <= fval_in;    bit_ff <= bit_in;
      s_ff <= s_in;          livecnt_ff <= livecnt_in;
      total_ff <= total_in;  i_ff <= i_in;          found_ff <= found_in;
      best_ff <= best_in;    bw_ff <= bw_in;
      a_ff <= a_in;          wa_ff <= wa_in;        b_ff <= b_in;
      node_ff <= node_in;    up_ff <= up_in;        len_ff <= len_in;
      code_ff <= code_in;
      pst_ff <= pst_in;      psym_ff <= psym_in;    pcode_ff <= pcode_in;
      plen_ff <= plen_in;
      ost_ff <= ost_in;      osym_ff <= osym_in;    ocode_ff <= ocode_in;
      olen_ff <= olen_in;
   end

   hce_ram #(.WIDTH(FREQ_BITS), .DEPTH(SYMBOL_COUNT)) u_freq (
      .clock(clock), .we(freq_we), .waddr(freq_wa), .wdata(freq_wd),
      .raddr(freq_ra), .rdata(freq_rd));

   hce_ram #(.WIDTH(WB+1), .DEPTH(NODE_MAX)) u_weight (
      .clock(clock), .we(weight_we), .waddr(weight_wa), .wdata(weight_wd),
      .raddr(i_ff), .rdata(weight_rd));

   hce_ram #(.WIDTH(NW), .DEPTH(NODE_MAX)) u_parent (
      .clock(clock), .we(parent_we), .waddr(parent_wa), .wdata(parent_wd),
      .raddr(node_ff), .rdata(parent_rd));

   hce_ram #(.WIDTH(NW), .DEPTH(NODE_MAX)) u_left (
      .clock(clock), .we(left_we), .waddr(total_ff), .wdata(a_ff),
      .raddr(dec_cur), .rdata(left_rd));

   hce_ram #(.WIDTH(NW), .DEPTH(NODE_MAX)) u_right (
      .clock(clock), .we(right_we), .waddr(total_ff), .wdata(best_ff),
      .raddr(right_ra), .rdata(right_rd));

   hce_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOL_COUNT)) u_nsym (
      .clock(clock), .we(nsym_we), .waddr(n_ff[SW-1:0]), .wdata(SYM_W'(s_ff)),
      .raddr(nsym_ra), .rdata(nsym_rd));

   hce_ram #(.WIDTH(NW+1), .DEPTH(SYMBOL_COUNT)) u_leafof (
      .clock(clock), .we(leafof_we), .waddr(s_idx),
      .wdata({(leaf_cur != '0), NW'(n_ff)}),
      .raddr(sym_idx), .rdata(leafof_rd));

   assign rsp_status         = ost_ff;
   assign rsp_decoded_symbol = osym_ff;
   assign rsp_code_bits      = ocode_ff;
   assign rsp_code_length    = olen_ff;
endmodule

// ===== hdl/hce_ctrl.sv =====
// Controller of the Huffman unit: sequences each operation as datapath
// micro-operations and owns the request and response handshakes.
// Depends on hce_pkg.
module hce_ctrl
   import hce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_operation,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_CNT_RD, S_CNT_WR, S_SET, S_CLR,
      S_BLD_INIT, S_LEAF_RD, S_LEAF_WR, S_MERGE, S_SCAN_INIT, S_SCAN_RD,
      S_SCAN_CMP, S_LINK,
      S_ENC_CHK, S_ENC_LEAF, S_ENC_PRD, S_ENC_RRD, S_ENC_STEP,
      S_DEC_CHK, S_DEC_STEP, S_DEC_SYM, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = DP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_LOAD;
               case (req_operation)
                  OP_COUNT:  state_in = S_CNT_RD;
                  OP_SET:    state_in = S_SET;
                  OP_BUILD:  state_in = S_BLD_INIT;
                  OP_ENCODE: state_in = S_ENC_CHK;
                  OP_DECODE: state_in = S_DEC_CHK;
                  OP_CLEAR:  state_in = S_CLR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CNT_RD: state_in = S_CNT_WR;
         S_CNT_WR: begin
            cmd.op = DP_CNT_WR;  state_in = S_IDLE;
         end
         S_SET: begin
            cmd.op = DP_SET_WR;  state_in = S_IDLE;
         end
         S_CLR: begin
            cmd.op = DP_CLEAR;  state_in = S_IDLE;
         end
         S_BLD_INIT: begin
            cmd.op = DP_BUILD_INIT;  state_in = S_LEAF_RD;
         end
         S_LEAF_RD: begin
            if (stat.leaf_more) begin
               cmd.op = DP_LEAF_RD;  state_in = S_LEAF_WR;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_LEAF_WR: begin
            cmd.op = DP_LEAF_WR;  state_in = S_LEAF_RD;
         end
         S_MERGE: begin
            if (stat.no_leaves) begin
               cmd.op = DP_BUILD_EMPTY;  state_in = S_EMIT;
            end else if (stat.merge_more) begin
               cmd.op = DP_SCAN_INIT;  state_in = S_SCAN_RD;
            end else begin
               cmd.op = DP_BUILD_DONE;  state_in = S_EMIT;
            end
         end
         S_SCAN_INIT: begin
            cmd.op = DP_SCAN_INIT;  state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (stat.scan_more) begin
               cmd.op = DP_SCAN_RD;  state_in = S_SCAN_CMP;
            end else if (!stat.second) begin
               cmd.op = DP_TAKE_A;  state_in = S_SCAN_INIT;
            end else begin
               cmd.op = DP_TAKE_B;  state_in = S_LINK;
            end
         end
         S_SCAN_CMP: begin
            cmd.op = DP_SCAN_CMP;  state_in = S_SCAN_RD;
         end
         S_LINK: begin
            cmd.op = DP_LINK_B;  state_in = S_MERGE;
         end
         S_ENC_CHK: begin
            cmd.op   = DP_ENC_CHK;
            state_in = stat.enc_fail ? S_EMIT : S_ENC_LEAF;
         end
         S_ENC_LEAF: begin
            cmd.op   = DP_ENC_LEAF;
            state_in = stat.enc_absent ? S_EMIT : S_ENC_PRD;
         end
         S_ENC_PRD: begin
            if (stat.enc_done) begin
               cmd.op = DP_ENC_FIN;  state_in = S_EMIT;
            end else begin
               cmd.op = DP_ENC_PRD;  state_in = S_ENC_RRD;
            end
         end
         S_ENC_RRD: begin
            cmd.op = DP_ENC_RRD;  state_in = S_ENC_STEP;
         end
         S_ENC_STEP: begin
            cmd.op = DP_ENC_STEP;  state_in = S_ENC_PRD;
         end
         S_DEC_CHK: begin
            cmd.op = DP_DEC_CHK;
            if (stat.dec_noready) begin
               state_in = S_EMIT;
            end else if (stat.dec_rootleaf) begin
               state_in = S_DEC_SYM;
            end else begin
               state_in = S_DEC_STEP;
            end
         end
         S_DEC_STEP: begin
            cmd.op = DP_DEC_STEP;
            if (stat.next_bad) begin
               state_in = S_EMIT;
            end else if (stat.next_leaf) begin
               state_in = S_DEC_SYM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DEC_SYM: begin
            cmd.op = DP_DEC_SYM;  state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
